### rtl/core/datetime_text_to_epoch_ns_macros.svh
// assertion macros for the checker file
`ifndef DATETIME_TEXT_TO_EPOCH_NS_MACROS_SVH
`define DATETIME_TEXT_TO_EPOCH_NS_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define DTTE_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dtte port check failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define DTTE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dtte port check failed");

`endif

### rtl/core/dtte_pkg.sv
`default_nettype none

package dtte_pkg;

    // ascii codes of the layout characters
    localparam logic [7:0] CH_DASH  = 8'h2d;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_DOT   = 8'h2e;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // character positions of the text
    localparam logic [4:0] POS_YEAR_END  = 5'd3;
    localparam logic [4:0] POS_MONTH_SEP = 5'd4;
    localparam logic [4:0] POS_MONTH_END = 5'd6;
    localparam logic [4:0] POS_DAY_SEP   = 5'd7;
    localparam logic [4:0] POS_DAY_END   = 5'd9;
    localparam logic [4:0] POS_DT_SEP    = 5'd10;
    localparam logic [4:0] POS_HOUR_END  = 5'd12;
    localparam logic [4:0] POS_HM_SEP    = 5'd13;
    localparam logic [4:0] POS_MIN_END   = 5'd15;
    localparam logic [4:0] POS_MS_SEP    = 5'd16;
    localparam logic [4:0] POS_SEC_END   = 5'd18;
    localparam logic [4:0] POS_FRAC_DOT  = 5'd19;
    localparam logic [4:0] POS_MAX       = 5'd31;

    // fraction digits kept, and digits of a nanosecond fraction
    localparam logic [3:0] MAX_FRACTION_DIGITS = 4'd9;
    localparam logic [3:0] NS_DIGITS           = 4'd9;

    // fraction scan phase
    localparam logic [1:0] FRAC_IDLE = 2'd0;
    localparam logic [1:0] FRAC_RUN  = 2'd1;
    localparam logic [1:0] FRAC_DONE = 2'd2;

    // result status codes
    localparam logic [2:0] STATUS_OK     = 3'd0;
    localparam logic [2:0] STATUS_LAYOUT = 3'd1;
    localparam logic [2:0] STATUS_DIGIT  = 3'd2;
    localparam logic [2:0] STATUS_DATE   = 3'd3;
    localparam logic [2:0] STATUS_OVF    = 3'd4;

    // one parsed text, handed from the parser to the converter
    typedef struct packed {
        logic        layout_fail;
        logic        digit_fail;
        logic [13:0] year;
        logic [6:0]  month;
        logic [6:0]  day;
        logic [6:0]  hour;
        logic [6:0]  minute;
        logic [6:0]  second;
        logic [29:0] frac_acc;
        logic [3:0]  frac_cnt;
    } dtte_rec_t;

    // converter sequence
    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV,
        S_CHK,
        S_DAYS,
        S_SEC,
        S_RANGE,
        S_MLO,
        S_MHI,
        S_SUM,
        S_OUT
    } dtte_state_t;

    // days in a month, zero for a month that does not exist
    function automatic logic [4:0] month_len(input logic [6:0] month, input logic leap);
        logic [4:0] len;
        unique case (month)
            7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12: len = 5'd31;
            7'd4, 7'd6, 7'd9, 7'd11:                    len = 5'd30;
            7'd2:                                       len = leap ? 5'd29 : 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

    // day of a march-based year on which a month starts
    function automatic logic [8:0] march_doy(input logic [3:0] mp);
        logic [8:0] doy;
        unique case (mp)
            4'd0:    doy = 9'd0;
            4'd1:    doy = 9'd31;
            4'd2:    doy = 9'd61;
            4'd3:    doy = 9'd92;
            4'd4:    doy = 9'd122;
            4'd5:    doy = 9'd153;
            4'd6:    doy = 9'd184;
            4'd7:    doy = 9'd214;
            4'd8:    doy = 9'd245;
            4'd9:    doy = 9'd275;
            4'd10:   doy = 9'd306;
            4'd11:   doy = 9'd337;
            default: doy = 9'd0;
        endcase
        return doy;
    endfunction

    // ten to the power n for a fraction scale
    function automatic logic [26:0] pow10(input logic [3:0] n);
        logic [26:0] p;
        unique case (n)
            4'd0:    p = 27'd1;
            4'd1:    p = 27'd10;
            4'd2:    p = 27'd100;
            4'd3:    p = 27'd1000;
            4'd4:    p = 27'd10000;
            4'd5:    p = 27'd100000;
            4'd6:    p = 27'd1000000;
            4'd7:    p = 27'd10000000;
            4'd8:    p = 27'd100000000;
            default: p = 27'd0;
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

### rtl/core/dtte_in_if.sv
`default_nettype none

interface dtte_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       last;

    modport source (output valid, output ch, output last, input ready);
    modport sink (input valid, input ch, input last, output ready);
endinterface

`default_nettype wire

### rtl/core/dtte_out_if.sv
`default_nettype none

interface dtte_out_if;
    logic               valid;
    logic               ready;
    logic signed [63:0] timestamp_ns;
    logic [2:0]         status;

    modport source (output valid, output timestamp_ns, output status, input ready);
    modport sink (input valid, input timestamp_ns, input status, output ready);
endinterface

`default_nettype wire

### rtl/core/datetime_text_to_epoch_ns.sv
// Datetime text to Unix epoch nanoseconds.
// text channel: one ASCII character per request (ch), last marks the final
// character of "yyyy-MM-dd HH:mm:ss[.fffffffff]". Characters are taken one
// per cycle while the text queue has room.
// epoch channel: one result per text, timestamp_ns (zero unless status is 0)
// and status (0 ok, 1 layout, 2 digits or time range, 3 date, 4 overflow).
// A valid text passes through every converter step; an overflow leaves after
// the range check, a failed layout, digit or date check right after the
// checks, plus any wait for the converter. The converter is a sequencer with
// its multiplications spread over its steps and takes one text at a time;
// the parser sustains one character per cycle, the QUEUE_DEPTH entry queue
// absorbs the difference. A result is held on the epoch channel until ready;
// meanwhile the parser keeps taking characters until the queue fills, then
// deasserts ready. Reset (rst_n low) clears the parser, the queue and the
// converter; no clearing pass is needed.
`default_nettype none

module datetime_text_to_epoch_ns #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic clk,
    input  wire logic rst_n,
    dtte_in_if.sink   text,
    dtte_out_if.source epoch
);
    import dtte_pkg::*;

    dtte_rec_t push_data;
    dtte_rec_t pop_data;
    logic      push, pop, full, empty;

    // character parser
    dtte_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .text      (text),
        .full      (full),
        .push      (push),
        .push_data (push_data)
    );

    // parsed text queue
    dtte_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (empty)
    );

    // epoch converter
    dtte_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .empty    (empty),
        .pop_data (pop_data),
        .pop      (pop),
        .epoch    (epoch)
    );

endmodule

`default_nettype wire

### rtl/core/dtte_front.sv
`default_nettype none

module dtte_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    dtte_in_if.sink            text,
    input  wire logic          full,
    output logic               push,
    output dtte_pkg::dtte_rec_t push_data
);
    import dtte_pkg::*;

    logic [4:0]  pos_reg, pos_next, pos_upd;
    logic [13:0] year_reg, year_next, year_upd;
    logic [6:0]  month_reg, month_next, month_upd;
    logic [6:0]  day_reg, day_next, day_upd;
    logic [6:0]  hour_reg, hour_next, hour_upd;
    logic [6:0]  minute_reg, minute_next, minute_upd;
    logic [6:0]  second_reg, second_next, second_upd;
    logic [29:0] frac_reg, frac_next, frac_upd;
    logic [3:0]  fcnt_reg, fcnt_next, fcnt_upd;
    logic [1:0]  phase_reg, phase_next, phase_upd;
    logic        layout_reg, layout_next, layout_upd;
    logic        digit_reg, digit_next, digit_upd;

    logic       accept;
    logic       isd;
    logic [3:0] d;

    // a request is taken whenever the queue has room
    assign text.ready = !full;
    assign accept     = text.valid && !full;
    assign isd        = (text.ch >= CH_ZERO) && (text.ch <= CH_NINE);
    assign d          = isd ? 4'(text.ch - CH_ZERO) : 4'd0;

    // per-position update of the field accumulators
    always_comb
    begin
        pos_upd    = pos_reg;
        year_upd   = year_reg;
        month_upd  = month_reg;
        day_upd    = day_reg;
        hour_upd   = hour_reg;
        minute_upd = minute_reg;
        second_upd = second_reg;
        frac_upd   = frac_reg;
        fcnt_upd   = fcnt_reg;
        phase_upd  = phase_reg;
        layout_upd = layout_reg;
        digit_upd  = digit_reg;
        if (accept)
        begin
            if (pos_reg <= POS_YEAR_END)
            begin
                if (isd) year_upd = 14'(year_reg * 14'd10 + 14'(d));
                else     digit_upd = 1'b1;
            end
            else if (pos_reg == POS_MONTH_SEP || pos_reg == POS_DAY_SEP)
            begin
                if (text.ch != CH_DASH) layout_upd = 1'b1;
            end
            else if (pos_reg <= POS_MONTH_END)
            begin
                if (isd) month_upd = 7'(month_reg * 7'd10 + 7'(d));
                else     digit_upd = 1'b1;
            end
            else if (pos_reg <= POS_DAY_END)
            begin
                if (isd) day_upd = 7'(day_reg * 7'd10 + 7'(d));
                else     digit_upd = 1'b1;
            end
            else if (pos_reg == POS_DT_SEP)
            begin
                if (text.ch != CH_SPACE && text.ch != CH_T) layout_upd = 1'b1;
            end
            else if (pos_reg <= POS_HOUR_END)
            begin
                if (isd) hour_upd = 7'(hour_reg * 7'd10 + 7'(d));
                else     digit_upd = 1'b1;
            end
            else if (pos_reg == POS_HM_SEP || pos_reg == POS_MS_SEP)
            begin
                if (text.ch != CH_COLON) layout_upd = 1'b1;
            end
            else if (pos_reg <= POS_MIN_END)
            begin
                if (isd) minute_upd = 7'(minute_reg * 7'd10 + 7'(d));
                else     digit_upd = 1'b1;
            end
            else if (pos_reg <= POS_SEC_END)
            begin
                if (isd) second_upd = 7'(second_reg * 7'd10 + 7'(d));
                else     digit_upd = 1'b1;
            end
            else if (pos_reg == POS_FRAC_DOT)
            begin
                phase_upd = (text.ch == CH_DOT) ? FRAC_RUN : FRAC_DONE;
            end
            else if (phase_reg == FRAC_RUN)
            begin
                if (!isd)
                    phase_upd = FRAC_DONE;
                else if (fcnt_reg < MAX_FRACTION_DIGITS)
                begin
                    frac_upd = 30'(frac_reg * 30'd10 + 30'(d));
                    fcnt_upd = fcnt_reg + 4'd1;
                end
                else
                    fcnt_upd = MAX_FRACTION_DIGITS + 4'd1;
            end

            if (pos_reg < POS_MAX) pos_upd = pos_reg + 5'd1;
        end
    end

    // on the final character hand the text on and start over
    always_comb
    begin
        push                  = accept && text.last;
        push_data.layout_fail = (pos_reg < POS_SEC_END) || layout_upd;
        push_data.digit_fail  = digit_upd;
        push_data.year        = year_upd;
        push_data.month       = month_upd;
        push_data.day         = day_upd;
        push_data.hour        = hour_upd;
        push_data.minute      = minute_upd;
        push_data.second      = second_upd;
        push_data.frac_acc    = frac_upd;
        push_data.frac_cnt    = fcnt_upd;
        if (push)
        begin
            pos_next    = '0;
            year_next   = '0;
            month_next  = '0;
            day_next    = '0;
            hour_next   = '0;
            minute_next = '0;
            second_next = '0;
            frac_next   = '0;
            fcnt_next   = '0;
            phase_next  = FRAC_IDLE;
            layout_next = 1'b0;
            digit_next  = 1'b0;
        end
        else
        begin
            pos_next    = pos_upd;
            year_next   = year_upd;
            month_next  = month_upd;
            day_next    = day_upd;
            hour_next   = hour_upd;
            minute_next = minute_upd;
            second_next = second_upd;
            frac_next   = frac_upd;
            fcnt_next   = fcnt_upd;
            phase_next  = phase_upd;
            layout_next = layout_upd;
            digit_next  = digit_upd;
        end
    end

    // parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            year_reg   <= '0;
            month_reg  <= '0;
            day_reg    <= '0;
            hour_reg   <= '0;
            minute_reg <= '0;
            second_reg <= '0;
            frac_reg   <= '0;
            fcnt_reg   <= '0;
            phase_reg  <= FRAC_IDLE;
            layout_reg <= 1'b0;
            digit_reg  <= 1'b0;
        end
        else
        begin
            pos_reg    <= pos_next;
            year_reg   <= year_next;
            month_reg  <= month_next;
            day_reg    <= day_next;
            hour_reg   <= hour_next;
            minute_reg <= minute_next;
            second_reg <= second_next;
            frac_reg   <= frac_next;
            fcnt_reg   <= fcnt_next;
            phase_reg  <= phase_next;
            layout_reg <= layout_next;
            digit_reg  <= digit_next;
        end
    end

endmodule

`default_nettype wire

### rtl/core/dtte_fifo.sv
`default_nettype none

module dtte_fifo #(
    parameter int DEPTH = 2
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire dtte_pkg::dtte_rec_t  push_data,
    output logic                      full,
    input  wire logic                 pop,
    output dtte_pkg::dtte_rec_t       pop_data,
    output logic                      empty
);
    import dtte_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    dtte_rec_t       mem_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            do_push, do_pop;

    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem_reg[rd_ptr_reg];

    // pointer wrap and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

`default_nettype wire

### rtl/core/dtte_back.sv
`default_nettype none

module dtte_back (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 empty,
    input  wire dtte_pkg::dtte_rec_t  pop_data,
    output logic                      pop,
    dtte_out_if.source                epoch
);
    import dtte_pkg::*;

    // yq = y / 100 for y below 16800: (y * 5243) >> 19
    localparam logic [12:0] DIV100_MUL   = 13'd5243;
    localparam int          DIV100_SHIFT = 19;
    // days from the shifted civil origin to 1970-01-01, plus one for day-of-month
    localparam logic [24:0] DAYS_OFFSET  = 25'd865566;
    localparam logic signed [17:0] DAY_SEC = 18'sd86400;
    localparam logic [29:0] NS_PER_S     = 30'd1000000000;
    localparam logic signed [41:0] SEC_MAX = 42'sd9223372036;
    localparam logic signed [41:0] SEC_MIN = -42'sd9223372037;
    localparam logic [29:0] FRAC_MAX     = 30'd854775807;
    localparam logic [29:0] FRAC_MIN     = 30'd145224192;

    dtte_state_t state_reg, state_next;

    dtte_rec_t          rec_reg;
    logic [7:0]         yq_reg;
    logic [14:0]        yp_reg;
    logic [8:0]         ypq_reg;
    logic signed [17:0] tod_reg;
    logic [29:0]        frac_reg;
    logic [2:0]         status_reg;
    logic signed [24:0] days_reg;
    logic signed [41:0] sec_reg;
    logic [63:0]        plo_reg;
    logic [31:0]        phi_reg;
    logic [63:0]        ts_reg;

    logic [13:0] year_rem;
    logic        leap;
    logic [4:0]  mlen;
    logic [2:0]  chk_status;
    logic [3:0]  mp;
    logic        frac_ok;
    logic        ovf;
    logic [31:0] sec_hi;

    // leap year from the registered quotient by 100
    assign year_rem = rec_reg.year - 14'(yq_reg * 14'd100);
    assign leap     = (rec_reg.year[1:0] == 2'b00)
                      && ((year_rem != '0) || (yq_reg[1:0] == 2'b00));
    assign mlen     = month_len(rec_reg.month, leap);

    // checks in priority order
    always_comb
    begin
        if (rec_reg.layout_fail)
            chk_status = STATUS_LAYOUT;
        else if (rec_reg.digit_fail || rec_reg.hour > 7'd23 || rec_reg.minute > 7'd59
                 || rec_reg.second > 7'd60)
            chk_status = STATUS_DIGIT;
        else if (rec_reg.day == '0 || rec_reg.day > 7'(mlen))
            chk_status = STATUS_DATE;
        else
            chk_status = STATUS_OK;
    end

    assign mp      = (rec_reg.month >= 7'd3) ? 4'(rec_reg.month - 7'd3)
                                             : 4'(rec_reg.month + 7'd9);
    assign frac_ok = (rec_reg.frac_cnt >= 4'd1) && (rec_reg.frac_cnt <= MAX_FRACTION_DIGITS);
    assign ovf     = (sec_reg > SEC_MAX) || (sec_reg < SEC_MIN)
                     || ((sec_reg == SEC_MAX) && (frac_reg > FRAC_MAX))
                     || ((sec_reg == SEC_MIN) && (frac_reg < FRAC_MIN));
    assign sec_hi  = {{22{sec_reg[41]}}, sec_reg[41:32]};

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (!empty) state_next = S_DIV;
            S_DIV:   state_next = S_CHK;
            S_CHK:   state_next = (chk_status == STATUS_OK) ? S_DAYS : S_OUT;
            S_DAYS:  state_next = S_SEC;
            S_SEC:   state_next = S_RANGE;
            S_RANGE: state_next = ovf ? S_OUT : S_MLO;
            S_MLO:   state_next = S_MHI;
            S_MHI:   state_next = S_SUM;
            S_SUM:   state_next = S_OUT;
            S_OUT:   if (epoch.ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // handshake outputs
    always_comb
    begin
        pop         = 1'b0;
        epoch.valid = 1'b0;
        unique case (state_reg)
            S_IDLE:  pop = !empty;
            S_OUT:   epoch.valid = 1'b1;
            default:
            begin
                pop         = 1'b0;
                epoch.valid = 1'b0;
            end
        endcase
    end

    assign epoch.status       = status_reg;
    assign epoch.timestamp_ns = (status_reg == STATUS_OK) ? $signed(ts_reg) : 64'sd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // conversion datapath, one step per state
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (!empty) rec_reg <= pop_data;
            end
            S_DIV:
            begin
                yq_reg  <= 8'((27'(rec_reg.year) * 27'(DIV100_MUL)) >> DIV100_SHIFT);
                yp_reg  <= 15'(rec_reg.year) + 15'd400
                           - ((rec_reg.month <= 7'd2) ? 15'd1 : 15'd0);
                tod_reg <= 18'(20'(rec_reg.hour) * 20'd3600 + 20'(rec_reg.minute) * 20'd60
                               + 20'(rec_reg.second));
            end
            S_CHK:
            begin
                status_reg <= chk_status;
                ypq_reg    <= 9'((28'(yp_reg) * 28'(DIV100_MUL)) >> DIV100_SHIFT);
                frac_reg   <= frac_ok
                              ? 30'(57'(rec_reg.frac_acc)
                                    * 57'(pow10(NS_DIGITS - rec_reg.frac_cnt)))
                              : 30'd0;
            end
            S_DAYS:
            begin
                days_reg <= $signed(25'(yp_reg) * 25'd365 + 25'(yp_reg[14:2])
                                    - 25'(ypq_reg) + 25'(ypq_reg[8:2])
                                    + 25'(march_doy(mp)) + 25'(rec_reg.day) - DAYS_OFFSET);
            end
            S_SEC:
            begin
                sec_reg <= 42'(days_reg * DAY_SEC + tod_reg);
            end
            S_RANGE:
            begin
                if (ovf) status_reg <= STATUS_OVF;
            end
            S_MLO:
            begin
                plo_reg <= 64'(sec_reg[31:0]) * 64'(NS_PER_S);
            end
            S_MHI:
            begin
                phi_reg <= 32'(sec_hi * 32'(NS_PER_S));
            end
            S_SUM:
            begin
                ts_reg <= plo_reg + {phi_reg, 32'd0} + 64'(frac_reg);
            end
            default:
            begin
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/core/dtte_checker.sv
`default_nettype none
`include "datetime_text_to_epoch_ns_macros.svh"

module dtte_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               out_valid,
    input wire logic               out_ready,
    input wire logic signed [63:0] out_timestamp_ns,
    input wire logic [2:0]         out_status
);
    import dtte_pkg::*;

    // a stalled result holds
    `DTTE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_timestamp_ns) && $stable(out_status))
    // a failed text carries a zero timestamp
    `DTTE_ASSERT_NOW(a_fail_zero, out_valid && (out_status != STATUS_OK), out_timestamp_ns == 64'sd0)
    // only the defined status codes appear
    `DTTE_ASSERT_NOW(a_status_code, out_valid, out_status <= STATUS_OVF)
    // the converter returns to idle after each delivered result
    `DTTE_ASSERT_NEXT(a_out_gap, out_valid && out_ready, !out_valid)

endmodule

bind datetime_text_to_epoch_ns dtte_checker u_dtte_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .out_valid        (epoch.valid),
    .out_ready        (epoch.ready),
    .out_timestamp_ns (epoch.timestamp_ns),
    .out_status       (epoch.status)
);

`default_nettype wire

### tb/datetime_text_to_epoch_ns_checker.sv
`timescale 1ns / 100ps

module datetime_text_to_epoch_ns_checker
    import dtte_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    dtte_in_if   text,
    dtte_out_if  epoch,
    output int   fails,
    output int   pending
);

    // limits of a 64-bit nanosecond count, split into seconds and fraction
    localparam longint SEC_HI      = 64'sd9223372036;
    localparam longint SEC_LO      = -64'sd9223372037;
    localparam longint FRAC_AT_HI  = 64'sd854775807;
    localparam longint FRAC_AT_LO  = 64'sd145224192;
    localparam longint NS_PER_SEC  = 64'sd1000000000;

    typedef struct {
        logic signed [63:0] timestamp_ns;
        logic [2:0]         status;
    } epoch_result_t;

    epoch_result_t expected_epochs[$];
    int            results_seen;

    // parser copy of the text being received
    logic [4:0]  pos_q;
    logic [13:0] year_q;
    logic [6:0]  month_q;
    logic [6:0]  day_q;
    logic [6:0]  hour_q;
    logic [6:0]  minute_q;
    logic [6:0]  second_q;
    logic [29:0] frac_q;
    logic [3:0]  frac_cnt_q;
    logic [1:0]  frac_phase_q;
    logic        layout_bad_q;
    logic        digit_bad_q;

    task automatic report_mismatch(input string msg);
        $display("epoch result %0d: %s", results_seen, msg);
        fails++;
    endtask

    task automatic clear_text();
        pos_q        = '0;
        year_q       = '0;
        month_q      = '0;
        day_q        = '0;
        hour_q       = '0;
        minute_q     = '0;
        second_q     = '0;
        frac_q       = '0;
        frac_cnt_q   = '0;
        frac_phase_q = FRAC_IDLE;
        layout_bad_q = 1'b0;
        digit_bad_q  = 1'b0;
    endtask

    function automatic int days_in_month(input logic [6:0] mon, input logic [13:0] yr);
        bit leap;
        int n;
        leap = (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
        case (mon)
            7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12: n = 31;
            7'd4, 7'd6, 7'd9, 7'd11:                    n = 30;
            7'd2:                                       n = leap ? 29 : 28;
            default:                                    n = 0;
        endcase
        return n;
    endfunction

    // day count from 1970-01-01, years counted from march
    function automatic longint civil_days(input longint yr, input longint mon,
                                          input longint dy);
        longint y;
        longint era;
        longint yoe;
        longint mp;
        longint doy;
        longint doe;
        y   = yr - ((mon <= 2) ? 1 : 0);
        era = ((y >= 0) ? y : y - 399) / 400;
        yoe = y - era * 400;
        mp  = (mon + 9) % 12;
        doy = (153 * mp + 2) / 5 + dy - 1;
        doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
        return era * 146097 + doe - 719468;
    endfunction

    // checks and conversion once the final character is in
    task automatic finish_text(input logic [4:0] end_pos);
        epoch_result_t res;
        logic [2:0]    status;
        longint        sec;
        longint        frac;
        status = STATUS_OK;
        if (end_pos < POS_SEC_END || layout_bad_q)
            status = STATUS_LAYOUT;
        else if (digit_bad_q || hour_q > 7'd23 || minute_q > 7'd59 || second_q > 7'd60)
            status = STATUS_DIGIT;
        else if (day_q < 7'd1 || int'(day_q) > days_in_month(month_q, year_q))
            status = STATUS_DATE;
        res.timestamp_ns = '0;
        if (status == STATUS_OK)
        begin
            frac = 0;
            if (frac_cnt_q >= 4'd1 && frac_cnt_q <= MAX_FRACTION_DIGITS)
            begin
                frac = longint'(frac_q);
                for (int k = int'(frac_cnt_q); k < int'(NS_DIGITS); k++)
                    frac = frac * 10;
            end
            sec = civil_days(longint'(year_q), longint'(month_q), longint'(day_q)) * 86400
                + longint'(hour_q) * 3600 + longint'(minute_q) * 60 + longint'(second_q);
            if (sec > SEC_HI || sec < SEC_LO)
                status = STATUS_OVF;
            else if (sec == SEC_HI && frac > FRAC_AT_HI)
                status = STATUS_OVF;
            else if (sec == SEC_LO && frac < FRAC_AT_LO)
                status = STATUS_OVF;
            else
                res.timestamp_ns = sec * NS_PER_SEC + frac;
        end
        res.status = status;
        expected_epochs.push_back(res);
    endtask

    // one character through the parser
    task automatic take_char(input logic [7:0] c, input logic is_last);
        logic [4:0] pos_at;
        logic       is_digit;
        logic       digit_field;
        int         digit;
        pos_at      = pos_q;
        is_digit    = (c >= CH_ZERO) && (c <= CH_NINE);
        digit       = is_digit ? int'(c - CH_ZERO) : 0;
        digit_field = 1'b1;
        if (pos_at <= POS_YEAR_END)
        begin
            if (is_digit)
                year_q = 14'(int'(year_q) * 10 + digit);
        end
        else if (pos_at == POS_MONTH_SEP || pos_at == POS_DAY_SEP)
        begin
            digit_field = 1'b0;
            if (c != CH_DASH)
                layout_bad_q = 1'b1;
        end
        else if (pos_at <= POS_MONTH_END)
        begin
            if (is_digit)
                month_q = 7'(int'(month_q) * 10 + digit);
        end
        else if (pos_at <= POS_DAY_END)
        begin
            if (is_digit)
                day_q = 7'(int'(day_q) * 10 + digit);
        end
        else if (pos_at == POS_DT_SEP)
        begin
            digit_field = 1'b0;
            if (c != CH_SPACE && c != CH_T)
                layout_bad_q = 1'b1;
        end
        else if (pos_at <= POS_HOUR_END)
        begin
            if (is_digit)
                hour_q = 7'(int'(hour_q) * 10 + digit);
        end
        else if (pos_at == POS_HM_SEP || pos_at == POS_MS_SEP)
        begin
            digit_field = 1'b0;
            if (c != CH_COLON)
                layout_bad_q = 1'b1;
        end
        else if (pos_at <= POS_MIN_END)
        begin
            if (is_digit)
                minute_q = 7'(int'(minute_q) * 10 + digit);
        end
        else if (pos_at <= POS_SEC_END)
        begin
            if (is_digit)
                second_q = 7'(int'(second_q) * 10 + digit);
        end
        else if (pos_at == POS_FRAC_DOT)
        begin
            digit_field  = 1'b0;
            frac_phase_q = (c == CH_DOT) ? FRAC_RUN : FRAC_DONE;
        end
        else
        begin
            // fraction digit run, anything after it is ignored
            digit_field = 1'b0;
            if (frac_phase_q == FRAC_RUN)
            begin
                if (!is_digit)
                    frac_phase_q = FRAC_DONE;
                else if (frac_cnt_q < MAX_FRACTION_DIGITS)
                begin
                    frac_q     = 30'(longint'(frac_q) * 10 + digit);
                    frac_cnt_q = frac_cnt_q + 4'd1;
                end
                else
                    frac_cnt_q = MAX_FRACTION_DIGITS + 4'd1;
            end
        end
        if (digit_field && !is_digit)
            digit_bad_q = 1'b1;
        if (pos_q < POS_MAX)
            pos_q = pos_q + 5'd1;
        if (is_last)
        begin
            finish_text(pos_at);
            clear_text();
        end
    endtask

    // watch both channels on each edge
    always @(posedge clk)
    begin : watch
        epoch_result_t want;
        if (!rst_n)
        begin
            clear_text();
            expected_epochs.delete();
            results_seen = 0;
            fails        = 0;
        end
        else
        begin
            if (text.valid && text.ready)
                take_char(text.ch, text.last);
            if (epoch.valid && epoch.ready)
            begin
                if (expected_epochs.size() == 0)
                    report_mismatch("result with no text pending");
                else
                begin
                    want = expected_epochs.pop_front();
                    if (epoch.status !== want.status)
                        report_mismatch($sformatf("status expected %0d got %0d",
                                                  want.status, epoch.status));
                    if (epoch.timestamp_ns !== want.timestamp_ns)
                        report_mismatch($sformatf("timestamp_ns expected %0d got %0d",
                                                  want.timestamp_ns, epoch.timestamp_ns));
                end
                results_seen++;
            end
        end
        pending = expected_epochs.size();
    end

endmodule

### tb/datetime_text_to_epoch_ns_tb.sv
`timescale 1ns / 100ps

module datetime_text_to_epoch_ns_tb;
    import dtte_pkg::*;

    localparam int CYCLE_LIMIT      = 400000;
    localparam int HOLD_CYCLES      = 2000;
    localparam int RANDOM_CHARS     = 370;
    localparam int RANDOM_TEXTS_MIN = 12;
    localparam int MAX_GAP          = 12;
    localparam int DRAIN_CYCLES     = 40;
    localparam int N_DIRECTED       = 28;

    logic clk = 1'b0;
    logic rst_n;
    logic rx_ready;
    logic hold_off;
    int   fails;
    int   pending;
    int   chars_sent;
    int   texts_sent;
    int   cycles;
    bit   tx_calm;
    logic [7:0] text_buf[$];

    // edges, every check and each odd text shape
    string directed_texts[N_DIRECTED] = '{
        "1970-01-01 00:00:00",
        "1970-01-01T00:00:00.5",
        "2262-04-11 23:47:16.854775807",
        "2262-04-11 23:47:16.854775808",
        "1677-09-21 00:12:43.145224192",
        "1677-09-21 00:12:43.145224191",
        "2000-02-29T12:34:56.123456789",
        "1900-02-29 00:00:00",
        "2023-13-01 00:00:00",
        "2023-04-00 10:00:00",
        "2023-04-31 10:00:00",
        "2023-01-01 24:00:00",
        "2023-01-01 23:60:00",
        "2016-12-31 23:59:60.999999999",
        "2023-01-01 23:59:61",
        "2023/01-01 00:00:00",
        "2023-01-01_00:00:00",
        "2023-01-01 00-00:00",
        "2023-01-01 00:00",
        "2023-01-01 00:00:0",
        "2O23-01-01 00:00:00",
        "2023-01-01 00:00:00.1234567891",
        "2023-01-01 00:00:00.",
        "2023-01-01 00:00:00Z+01:00",
        "1999-12-31 23:59:59.12x45678901234567",
        "9999-12-31 23:59:59",
        "0000-01-01 00:00:00",
        "X"
    };

    dtte_in_if  text_if ();
    dtte_out_if epoch_if ();

    assign epoch_if.ready = rx_ready && !hold_off;

    datetime_text_to_epoch_ns dut (
        .clk   (clk),
        .rst_n (rst_n),
        .text  (text_if),
        .epoch (epoch_if)
    );

    datetime_text_to_epoch_ns_checker checker_i (
        .clk     (clk),
        .rst_n   (rst_n),
        .text    (text_if),
        .epoch   (epoch_if),
        .fails   (fails),
        .pending (pending)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    task automatic append_str(input string s);
        for (int i = 0; i < s.len(); i++)
            text_buf.push_back(s[i]);
    endtask

    // one character request, returns at the edge that takes it
    task automatic send_char(input logic [7:0] c, input logic is_last);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            text_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        text_if.valid <= 1'b1;
        text_if.ch    <= c;
        text_if.last  <= is_last;
        do
            @(negedge clk);
        while (!text_if.ready);
        @(posedge clk);
        chars_sent++;
    endtask

    task automatic send_text();
        tx_calm = ($urandom_range(0, 3) == 0);
        foreach (text_buf[i])
            send_char(text_buf[i], i == text_buf.size() - 1);
        texts_sent++;
    endtask

    // mostly well-formed datetimes, some corrupted, cut short or pure noise
    task automatic make_random_text();
        int    kind;
        int    yr;
        int    mo;
        int    dy;
        int    hr;
        int    mi;
        int    sc;
        int    keep;
        string sep;
        text_buf.delete();
        kind = $urandom_range(0, 99);
        if (kind < 5)
        begin
            repeat ($urandom_range(1, 40))
                text_buf.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            case ($urandom_range(0, 9))
                0:       yr = $urandom_range(0, 9999);
                1:       yr = $urandom_range(0, 1) ? $urandom_range(2260, 2263)
                                                   : $urandom_range(1676, 1678);
                default: yr = $urandom_range(1678, 2261);
            endcase
            mo = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 99) : $urandom_range(1, 12);
            case ($urandom_range(0, 15))
                0:       dy = $urandom_range(0, 99);
                1, 2, 3: dy = $urandom_range(29, 31);
                default: dy = $urandom_range(1, 28);
            endcase
            hr = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 23);
            mi = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 59);
            case ($urandom_range(0, 15))
                0:       sc = $urandom_range(0, 99);
                1:       sc = 60;
                default: sc = $urandom_range(0, 59);
            endcase
            sep = $urandom_range(0, 1) ? "T" : " ";
            append_str($sformatf("%04d-%02d-%02d%s%02d:%02d:%02d", yr, mo, dy, sep, hr, mi, sc));
            // fraction: none, too long, empty or normal
            case ($urandom_range(0, 7))
                0: ;
                1:
                begin
                    text_buf.push_back(CH_DOT);
                    repeat ($urandom_range(10, 14))
                        text_buf.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
                end
                2: text_buf.push_back(CH_DOT);
                default:
                begin
                    text_buf.push_back(CH_DOT);
                    repeat ($urandom_range(1, 9))
                        text_buf.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
                end
            endcase
            if ($urandom_range(0, 5) == 0)
                repeat ($urandom_range(1, 6))
                    text_buf.push_back(8'($urandom_range(0, 255)));
            if (kind < 20)
            begin
                repeat ($urandom_range(1, 2))
                    text_buf[$urandom_range(0, text_buf.size() - 1)] = 8'($urandom_range(0, 255));
            end
            else if (kind < 30)
            begin
                keep = $urandom_range(1, text_buf.size());
                while (text_buf.size() > keep)
                    void'(text_buf.pop_back());
            end
        end
    endtask

    // text requests and the verdict
    initial
    begin
        int random_start;
        rst_n         <= 1'b0;
        text_if.valid <= 1'b0;
        text_if.ch    <= 8'h00;
        text_if.last  <= 1'b0;
        chars_sent     = 0;
        texts_sent     = 0;
        tx_calm        = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_texts[i])
        begin
            text_buf.delete();
            append_str(directed_texts[i]);
            send_text();
        end
        // zero and all-ones bytes in the ignored tail
        text_buf.delete();
        append_str("1970-01-01 00:00:00");
        text_buf.push_back(8'h00);
        text_buf.push_back(8'hff);
        send_text();

        random_start = chars_sent;
        while (chars_sent - random_start < RANDOM_CHARS ||
               texts_sent < N_DIRECTED + 1 + RANDOM_TEXTS_MIN)
        begin
            make_random_text();
            send_text();
        end
        text_if.valid <= 1'b0;

        // drain outstanding results
        do
            @(negedge clk);
        while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fails == 0)
            $display("datetime_text_to_epoch_ns: match");
        else
            $display("datetime_text_to_epoch_ns: mismatch");
        $finish;
    end

    // result side with random stalls and calm stretches
    initial
    begin
        int gap;
        bit rx_calm;
        rx_ready <= 1'b0;
        rx_calm   = 1'b0;
        do
            @(posedge clk);
        while (!rst_n);
        forever
        begin
            if ($urandom_range(0, 9) == 0)
                rx_calm = !rx_calm;
            gap = rx_calm ? 0 : $urandom_range(0, MAX_GAP);
            if (gap > 0)
            begin
                rx_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            rx_ready <= 1'b1;
            do
                @(negedge clk);
            while (!(epoch_if.valid && epoch_if.ready));
            @(posedge clk);
        end
    end

    // one long hold-off on results so the queue fills and text stalls
    initial
    begin
        hold_off <= 1'b0;
        do
            @(negedge clk);
        while (texts_sent < N_DIRECTED + 4);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    // run limit
    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("datetime_text_to_epoch_ns: mismatch");
        $finish;
    end

endmodule
